// ----- rtl/core/mfp_pkg.sv -----
// Shared types and constants for the smallest-factorial-multiple block.
package mfp_pkg;

    localparam int unsigned NUM_W    = 16;
    localparam int unsigned RES_W    = 32;
    localparam int unsigned TABLE_MAX = 65535;

    // One query as it travels from the front end to the engine
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [NUM_W-1:0] power;
        logic             trivial;
    } t_job;

    typedef enum logic [4:0] {
        S_INIT,
        S_SV_I,
        S_SV_IC,
        S_SV_JR,
        S_SV_JC,
        S_IDLE,
        S_FAC,
        S_SPFW,
        S_TD,
        S_TDW,
        S_EDIV,
        S_EDW,
        S_GOAL,
        S_HI,
        S_BS,
        S_LG,
        S_LGW,
        S_OUT
    } t_state;

endpackage

// ----- rtl/core/mfp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mfp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- rtl/core/mfp_front.sv -----
// Front end: accepts queries, flags trivial ones and queues them for the engine.
module mfp_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_enable,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mfp_pkg::NUM_W-1:0] i_number,
    input  logic [mfp_pkg::NUM_W-1:0] i_power,
    output logic                      o_job_valid,
    input  logic                      i_job_ready,
    output mfp_pkg::t_job             o_job
);

    mfp_pkg::t_job r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    mfp_pkg::t_job in_job;

    // Classify the incoming beat
    always_comb begin
        in_job.number  = i_number;
        in_job.power   = i_power;
        in_job.trivial = (i_number < 16'd2) || (i_power == '0);
    end

    assign o_ready     = i_enable && (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    // Hold queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/core/mfp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module mfp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [15:0] o_rem
);

    logic [31:0] r_q;
    logic [16:0] r_r;
    logic [15:0] r_dv;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic [17:0] diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_r[15:0], r_q[31]};
        diff  = {1'b0, trial} - {2'b00, r_dv};
    end

    // Step the division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the division
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= i_dividend;
            r_r  <= '0;
            r_dv <= i_divisor;
        end else if (r_busy) begin
            if (!diff[17]) begin
                r_r <= diff[16:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= trial;
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[15:0];

endmodule

// ----- rtl/core/mfp_back.sv -----
// Engine: fills the factor table after reset, then factors and searches per query.
module mfp_back #(
    parameter int unsigned MAX_VALUE = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    output logic                      o_table_ready,
    input  logic                      i_job_valid,
    output logic                      o_job_ready,
    input  mfp_pkg::t_job             i_job,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mfp_pkg::RES_W-1:0] o_least_m
);

    localparam int unsigned LIMIT = (MAX_VALUE > mfp_pkg::TABLE_MAX) ?
                                    mfp_pkg::TABLE_MAX : MAX_VALUE;
    localparam int unsigned DEPTH = LIMIT + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    mfp_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_init, n_init;
    logic [8:0]    r_si, n_si;
    logic [16:0]   r_sj, n_sj;
    logic [15:0]   r_x, n_x;
    logic [15:0]   r_pw, n_pw;
    logic [15:0]   r_p, n_p;
    logic [4:0]    r_e, n_e;
    logic [20:0]   r_goal, n_goal;
    logic [8:0]    r_d, n_d;
    logic [31:0]   r_lo, n_lo;
    logic [31:0]   r_hi, n_hi;
    logic [31:0]   r_mid, n_mid;
    logic [31:0]   r_t, n_t;
    logic [33:0]   r_cnt, n_cnt;
    logic [31:0]   r_best, n_best;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out, n_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    logic          div_start;
    logic [31:0]   div_dividend;
    logic [15:0]   div_divisor;
    logic          div_done;
    logic [31:0]   div_quot;
    logic [15:0]   div_rem;

    logic [17:0]   si_sq;
    logic [17:0]   d_sq;
    logic [32:0]   lo_hi_sum;
    logic [36:0]   hi_prod;
    logic [33:0]   cnt_sum;

    mfp_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_spf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mfp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign si_sq     = {9'd0, r_si} * {9'd0, r_si};
    assign d_sq      = {9'd0, r_d} * {9'd0, r_d};
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign hi_prod   = {21'd0, r_p} * {16'd0, r_goal};
    assign cnt_sum   = r_cnt + {2'b00, div_quot};

    // Next state, datapath and control
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_si        = r_si;
        n_sj        = r_sj;
        n_x         = r_x;
        n_pw        = r_pw;
        n_p         = r_p;
        n_e         = r_e;
        n_goal      = r_goal;
        n_d         = r_d;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_t         = r_t;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        wr_en        = 1'b0;
        wr_addr      = r_init;
        wr_data      = 16'(r_init);
        rd_en        = 1'b0;
        rd_addr      = AW'(r_x);
        div_start    = 1'b0;
        div_dividend = {16'd0, r_x};
        div_divisor  = r_p;
        o_job_ready  = 1'b0;

        unique case (r_state)
            // Write each index with itself
            mfp_pkg::S_INIT: begin
                wr_en = 1'b1;
                if (r_init == AW'(LIMIT)) begin
                    n_si    = 9'd2;
                    n_state = mfp_pkg::S_SV_I;
                end else begin
                    n_init = r_init + 1'b1;
                end
            end
            mfp_pkg::S_SV_I: begin
                if (si_sq > 18'(LIMIT)) begin
                    n_state = mfp_pkg::S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_si);
                    n_state = mfp_pkg::S_SV_IC;
                end
            end
            mfp_pkg::S_SV_IC: begin
                if (rd_data == {7'd0, r_si}) begin
                    n_sj    = si_sq[16:0];
                    n_state = mfp_pkg::S_SV_JR;
                end else begin
                    n_si    = r_si + 9'd1;
                    n_state = mfp_pkg::S_SV_I;
                end
            end
            mfp_pkg::S_SV_JR: begin
                if (r_sj > 17'(LIMIT)) begin
                    n_si    = r_si + 9'd1;
                    n_state = mfp_pkg::S_SV_I;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_sj);
                    n_state = mfp_pkg::S_SV_JC;
                end
            end
            // Mark the multiple if nothing smaller claimed it
            mfp_pkg::S_SV_JC: begin
                wr_addr = AW'(r_sj);
                wr_data = {7'd0, r_si};
                wr_en   = (rd_data == r_sj[15:0]);
                n_sj    = r_sj + {8'd0, r_si};
                n_state = mfp_pkg::S_SV_JR;
            end
            mfp_pkg::S_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_x    = i_job.number;
                    n_pw   = i_job.power;
                    n_best = '0;
                    n_state = i_job.trivial ? mfp_pkg::S_OUT : mfp_pkg::S_FAC;
                end
            end
            // Pick the next prime factor
            mfp_pkg::S_FAC: begin
                if (r_x < 16'd2) begin
                    n_state = mfp_pkg::S_OUT;
                end else if (r_x <= 16'(LIMIT)) begin
                    rd_en   = 1'b1;
                    n_state = mfp_pkg::S_SPFW;
                end else begin
                    n_d     = 9'd2;
                    n_state = mfp_pkg::S_TD;
                end
            end
            mfp_pkg::S_SPFW: begin
                n_p     = (rd_data < 16'd2) ? r_x : rd_data;
                n_e     = '0;
                n_state = mfp_pkg::S_EDIV;
            end
            // Trial division beyond the table
            mfp_pkg::S_TD: begin
                if (d_sq > {2'b00, r_x}) begin
                    n_p     = r_x;
                    n_e     = '0;
                    n_state = mfp_pkg::S_EDIV;
                end else begin
                    div_start   = 1'b1;
                    div_divisor = {7'd0, r_d};
                    n_state     = mfp_pkg::S_TDW;
                end
            end
            mfp_pkg::S_TDW: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_p     = {7'd0, r_d};
                        n_e     = '0;
                        n_state = mfp_pkg::S_EDIV;
                    end else begin
                        n_d     = r_d + 9'd1;
                        n_state = mfp_pkg::S_TD;
                    end
                end
            end
            // Strip the prime, counting its multiplicity
            mfp_pkg::S_EDIV: begin
                div_start = 1'b1;
                n_state   = mfp_pkg::S_EDW;
            end
            mfp_pkg::S_EDW: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_x     = div_quot[15:0];
                        n_e     = r_e + 5'd1;
                        n_state = mfp_pkg::S_EDIV;
                    end else begin
                        n_state = mfp_pkg::S_GOAL;
                    end
                end
            end
            mfp_pkg::S_GOAL: begin
                n_goal  = {16'd0, r_e} * {5'd0, r_pw};
                n_state = mfp_pkg::S_HI;
            end
            mfp_pkg::S_HI: begin
                n_lo    = '0;
                n_hi    = hi_prod[31:0];
                n_state = mfp_pkg::S_BS;
            end
            // Binary search on m
            mfp_pkg::S_BS: begin
                if (r_lo < r_hi) begin
                    n_mid   = lo_hi_sum[32:1];
                    n_t     = lo_hi_sum[32:1];
                    n_cnt   = '0;
                    n_state = mfp_pkg::S_LG;
                end else begin
                    if (r_lo > r_best) begin
                        n_best = r_lo;
                    end
                    n_state = mfp_pkg::S_FAC;
                end
            end
            mfp_pkg::S_LG: begin
                if (r_t < {16'd0, r_p}) begin
                    n_lo    = r_mid + 32'd1;
                    n_state = mfp_pkg::S_BS;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = r_t;
                    n_state      = mfp_pkg::S_LGW;
                end
            end
            // Accumulate the Legendre count
            mfp_pkg::S_LGW: begin
                if (div_done) begin
                    n_t   = div_quot;
                    n_cnt = cnt_sum;
                    if (cnt_sum >= {13'd0, r_goal}) begin
                        n_hi    = r_mid;
                        n_state = mfp_pkg::S_BS;
                    end else begin
                        n_state = mfp_pkg::S_LG;
                    end
                end
            end
            mfp_pkg::S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_best;
                    n_out_valid = 1'b1;
                    n_state     = mfp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mfp_pkg::S_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfp_pkg::S_INIT;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_x    <= n_x;
        r_pw   <= n_pw;
        r_p    <= n_p;
        r_e    <= n_e;
        r_goal <= n_goal;
        r_d    <= n_d;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_t    <= n_t;
        r_cnt  <= n_cnt;
        r_best <= n_best;
        r_out  <= n_out;
    end

    assign o_table_ready = (r_state != mfp_pkg::S_INIT) && (r_state != mfp_pkg::S_SV_I) &&
                           (r_state != mfp_pkg::S_SV_IC) && (r_state != mfp_pkg::S_SV_JR) &&
                           (r_state != mfp_pkg::S_SV_JC);
    assign o_valid   = r_out_valid;
    assign o_least_m = r_out;

    // No job is taken while the table is still being built
    a_no_job_in_sieve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && o_job_ready) |-> o_table_ready)
        else $error("job taken during table fill");

    // A division is only started while the divider is idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !((r_state == mfp_pkg::S_TDW) || (r_state == mfp_pkg::S_EDW) ||
                        (r_state == mfp_pkg::S_LGW)))
        else $error("divider restarted while busy");

    // A prime reaches the search with a nonzero multiplicity
    a_mult_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfp_pkg::S_GOAL) |-> (r_e != '0))
        else $error("zero multiplicity");

    // The search interval never inverts
    a_bs_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfp_pkg::S_LG) |-> (r_lo <= r_mid) && (r_mid < r_hi))
        else $error("search interval broken");

endmodule

// ----- rtl/core/min_factorial_multiple_of_power.sv -----
// Flow: a trivial query (number below two or power zero) goes from the queue straight to the output register.
// Otherwise each prime costs (e+1) divider passes to strip it
// and about 32 search probes of up to log_p(m) divider passes each.
// Throughput: one query at a time in the engine; a two-entry queue and an output
// register let the front end and the consumer stall independently.
// Reset: the factor table is filled and sieved first.
module min_factorial_multiple_of_power #(
    parameter int unsigned MAX_VALUE = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mfp_pkg::NUM_W-1:0] i_number,
    input  logic [mfp_pkg::NUM_W-1:0] i_power,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mfp_pkg::RES_W-1:0] o_least_m
);

    logic          table_ready;
    logic          job_valid;
    logic          job_ready;
    mfp_pkg::t_job job;

    mfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (table_ready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_number    (i_number),
        .i_power     (i_power),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    mfp_back #(
        .MAX_VALUE (MAX_VALUE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_table_ready (table_ready),
        .i_job_valid   (job_valid),
        .o_job_ready   (job_ready),
        .i_job         (job),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_least_m     (o_least_m)
    );

endmodule
